FILE: hw/rtl/xsed_pkg.sv
// Package for the cross-reference stream entry decoder.
// Holds field widths, request/status/kind codes, register indexes and shared types.
// No dependencies; every other file of the block imports it.
package xsed_pkg;

    localparam int unsigned OBJ_W   = 31;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WIDTH_W = 3;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam logic [OBJ_W-1:0] OBJ_MAX = {OBJ_W{1'b1}};

    // Request codes on the input channel; the fourth code is ignored.
    typedef enum logic [1:0] {
        REQ_SUBSECTION = 2'd0,
        REQ_DATA       = 2'd1,
        REQ_END        = 2'd2
    } t_req_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_ENTRY     = 2'd0,
        ST_CLEAN_END = 2'd1,
        ST_TRUNC_END = 2'd2,
        ST_ERROR     = 2'd3
    } t_status;

    // Entry kinds.
    typedef enum logic [1:0] {
        KIND_FREE       = 2'd0,
        KIND_IN_USE     = 2'd1,
        KIND_COMPRESSED = 2'd2
    } t_entry_kind;

    // Configuration register indexes (word address bits).
    typedef enum logic [1:0] {
        REG_TYPE_WIDTH   = 2'd0,
        REG_SECOND_WIDTH = 2'd1,
        REG_THIRD_WIDTH  = 2'd2
    } t_reg_idx;

    // Field widths in bytes as held by the configuration registers.
    typedef struct packed {
        logic [WIDTH_W-1:0] type_width;
        logic [WIDTH_W-1:0] second_width;
        logic [WIDTH_W-1:0] third_width;
    } t_cfg;

    // One request word held in the input register.
    typedef struct packed {
        logic [1:0]        req_type;
        logic [BYTE_W-1:0] data_byte;
        logic [OBJ_W-1:0]  first_object;
        logic [OBJ_W-1:0]  entry_count;
    } t_req;

endpackage

FILE: hw/rtl/xsed_if.sv
// Stream interfaces of the cross-reference stream entry decoder.
// xsed_req_if carries request words, xsed_rsp_if carries result words.
// Depends on xsed_pkg for the field widths.
interface xsed_req_if;
    import xsed_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          req_type;
    logic [BYTE_W-1:0]   data_byte;
    logic [OBJ_W-1:0]    first_object;
    logic [OBJ_W-1:0]    entry_count;

    modport source (
        output valid, req_type, data_byte, first_object, entry_count,
        input  ready
    );
    modport sink (
        input  valid, req_type, data_byte, first_object, entry_count,
        output ready
    );
endinterface

interface xsed_rsp_if;
    import xsed_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [1:0]          entry_kind;
    logic [OBJ_W-1:0]    object_number;
    logic [VAL_W-1:0]    location;
    logic [VAL_W-1:0]    generation_or_index;

    modport source (
        output valid, status, entry_kind, object_number, location, generation_or_index,
        input  ready
    );
    modport sink (
        input  valid, status, entry_kind, object_number, location, generation_or_index,
        output ready
    );
endinterface

FILE: hw/rtl/xsed_apb_regs.sv
// Configuration registers of the entry decoder behind an APB-style port.
// Holds the type, second and third field widths in bytes.
// Depends on xsed_pkg.
module xsed_apb_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [xsed_pkg::ADDR_W-1:0] paddr,
    input  logic [xsed_pkg::DATA_W-1:0] pwdata,
    output logic [xsed_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output xsed_pkg::t_cfg            o_cfg
);
    import xsed_pkg::*;

    logic [WIDTH_W-1:0] r_type_width;
    logic [WIDTH_W-1:0] r_second_width;
    logic [WIDTH_W-1:0] r_third_width;
    logic               w_write;
    t_reg_idx           w_idx;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite && pready;
    assign w_idx   = t_reg_idx'(paddr[3:2]);

    // Register writes; addresses beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_width   <= WIDTH_W'(1);
            r_second_width <= WIDTH_W'(4);
            r_third_width  <= WIDTH_W'(2);
        end else if (w_write) begin
            case (w_idx)
                REG_TYPE_WIDTH:   r_type_width   <= pwdata[WIDTH_W-1:0];
                REG_SECOND_WIDTH: r_second_width <= pwdata[WIDTH_W-1:0];
                REG_THIRD_WIDTH:  r_third_width  <= pwdata[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_TYPE_WIDTH:   prdata = DATA_W'(r_type_width);
            REG_SECOND_WIDTH: prdata = DATA_W'(r_second_width);
            REG_THIRD_WIDTH:  prdata = DATA_W'(r_third_width);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.type_width   = r_type_width;
    assign o_cfg.second_width = r_second_width;
    assign o_cfg.third_width  = r_third_width;

endmodule

FILE: hw/rtl/xsed_decode.sv
// Decode stage of the entry decoder: entry state, field assembly and result register.
// Takes one registered request word per cycle unless its result stalls; drives o_rsp.
// Depends on xsed_pkg and xsed_if.
module xsed_decode #(
    parameter int unsigned MAX_FIELD_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xsed_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  xsed_pkg::t_req    i_req,
    output logic              o_take,
    xsed_rsp_if.source        o_rsp
);
    import xsed_pkg::*;

    localparam int unsigned POS_W = $clog2(3 * MAX_FIELD_BYTES + 1);
    localparam logic [3:0]  MAXW  = 4'(MAX_FIELD_BYTES);

    // Entry state.
    logic [POS_W-1:0] r_pos,    n_pos;
    logic [VAL_W-1:0] r_acc,    n_acc;
    logic [VAL_W-1:0] r_type,   n_type;
    logic [VAL_W-1:0] r_second, n_second;
    logic [OBJ_W-1:0] r_obj,    n_obj;
    logic [OBJ_W-1:0] r_remain, n_remain;
    logic             r_err,    n_err;

    // Result register.
    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [1:0]       r_kind;
    logic [OBJ_W-1:0] r_out_obj;
    logic [VAL_W-1:0] r_loc;
    logic [VAL_W-1:0] r_gen;

    logic             w_has_res;
    t_status          w_status;
    t_entry_kind      w_kind;
    logic [OBJ_W-1:0] w_obj;
    logic [VAL_W-1:0] w_loc;
    logic [VAL_W-1:0] w_gen;

    logic [3:0]       w_ta4, w_tb4, w_tc4;
    logic [POS_W-1:0] w_ta, w_tb, w_tc, w_len, w_np, w_tab;
    logic [VAL_W-1:0] w_shift;

    // Clamp widths to the supported field size; a zero second width is taken as 1.
    always_comb begin
        w_ta4 = ({1'b0, i_cfg.type_width} > MAXW) ? MAXW : {1'b0, i_cfg.type_width};
        w_tc4 = ({1'b0, i_cfg.third_width} > MAXW) ? MAXW : {1'b0, i_cfg.third_width};
        if (i_cfg.second_width == '0) begin
            w_tb4 = 4'd1;
        end else if ({1'b0, i_cfg.second_width} > MAXW) begin
            w_tb4 = MAXW;
        end else begin
            w_tb4 = {1'b0, i_cfg.second_width};
        end
    end

    assign w_ta    = POS_W'(w_ta4);
    assign w_tb    = POS_W'(w_tb4);
    assign w_tc    = POS_W'(w_tc4);
    assign w_tab   = w_ta + w_tb;
    assign w_len   = w_tab + w_tc;
    assign w_np    = r_pos + POS_W'(1);
    assign w_shift = {r_acc[VAL_W-BYTE_W-1:0], i_req.data_byte};

    // The word in the input register moves on when the result slot is free or drains.
    assign o_take = i_valid && (!r_out_valid || o_rsp.ready);

    // Next state and result for the word in the input register.
    always_comb begin
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_type    = r_type;
        n_second  = r_second;
        n_obj     = r_obj;
        n_remain  = r_remain;
        n_err     = r_err;
        w_has_res = 1'b0;
        w_status  = ST_ENTRY;
        w_kind    = KIND_FREE;
        w_obj     = '0;
        w_loc     = '0;
        w_gen     = '0;
        case (t_req_kind'(i_req.req_type))
            REQ_SUBSECTION: begin
                if (r_remain != '0 || r_pos != '0) begin
                    n_err = 1'b1;
                end
                n_obj    = i_req.first_object;
                n_remain = i_req.entry_count;
                n_pos    = '0;
                n_acc    = '0;
            end
            REQ_DATA: begin
                if (r_remain == '0) begin
                    // Byte beyond the entry count is dropped.
                    n_err = 1'b1;
                end else begin
                    n_pos = w_np;
                    n_acc = w_shift;
                    if (w_ta != '0 && w_np == w_ta) begin
                        n_type = w_shift;
                        n_acc  = '0;
                    end
                    if (w_np == w_tab) begin
                        n_second = w_shift;
                        n_acc    = '0;
                    end
                    if (w_np >= w_len) begin
                        // Entry complete; a missing type field means in use.
                        w_obj = r_obj;
                        w_gen = n_acc;
                        if (w_ta == '0) begin
                            w_has_res = 1'b1;
                            w_kind    = KIND_IN_USE;
                            w_loc     = n_second;
                        end else if (n_type == VAL_W'(KIND_FREE)) begin
                            w_has_res = 1'b1;
                            w_kind    = KIND_FREE;
                        end else if (n_type == VAL_W'(KIND_IN_USE)) begin
                            w_has_res = 1'b1;
                            w_kind    = KIND_IN_USE;
                            w_loc     = n_second;
                        end else if (n_type == VAL_W'(KIND_COMPRESSED)) begin
                            w_has_res = 1'b1;
                            w_kind    = KIND_COMPRESSED;
                            w_loc     = n_second;
                        end else begin
                            n_err = 1'b1;
                        end
                        n_pos    = '0;
                        n_acc    = '0;
                        n_remain = r_remain - OBJ_W'(1);
                        if (r_obj != OBJ_MAX) begin
                            n_obj = r_obj + OBJ_W'(1);
                        end
                    end
                end
            end
            REQ_END: begin
                w_has_res = 1'b1;
                if (r_err) begin
                    w_status = ST_ERROR;
                end else if (r_remain != '0 || r_pos != '0) begin
                    w_status = ST_TRUNC_END;
                end else begin
                    w_status = ST_CLEAN_END;
                end
                n_err    = 1'b0;
                n_remain = '0;
                n_pos    = '0;
                n_acc    = '0;
            end
            default: ;
        endcase
    end

    // Entry state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_acc    <= '0;
            r_type   <= '0;
            r_second <= '0;
            r_obj    <= '0;
            r_remain <= '0;
            r_err    <= 1'b0;
        end else if (o_take) begin
            r_pos    <= n_pos;
            r_acc    <= n_acc;
            r_type   <= n_type;
            r_second <= n_second;
            r_obj    <= n_obj;
            r_remain <= n_remain;
            r_err    <= n_err;
        end
    end

    // Result register; holds its word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= w_has_res;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && w_has_res) begin
            r_status  <= w_status;
            r_kind    <= w_kind;
            r_out_obj <= w_obj;
            r_loc     <= w_loc;
            r_gen     <= w_gen;
        end
    end

    assign o_rsp.valid               = r_out_valid;
    assign o_rsp.status              = r_status;
    assign o_rsp.entry_kind          = r_kind;
    assign o_rsp.object_number       = r_out_obj;
    assign o_rsp.location            = r_loc;
    assign o_rsp.generation_or_index = r_gen;

endmodule

FILE: hw/rtl/xref_stream_entry_decoder.sv
// Cross-reference stream entry decoder, top level.
// Input register, configuration registers and the decode stage with its result register.
// Depends on xsed_pkg, xsed_if, xsed_apb_regs and xsed_decode.
//
// Usage:
//   i_req carries request words: subsection start (first object, entry count),
//   one decompressed stream byte, or end of data. o_rsp carries result words:
//   one per completed entry of type free, in use or compressed, and one per
//   end of data (clean, truncated or error seen). Bad types and stray bytes
//   give no word but set a sticky error that the end word reports and clears.
//   The APB port sets the byte widths of the three entry fields; write it only
//   while no request is in flight.
//   The request word is first registered in the input register; the decode stage
//   then writes its result into the result register once that register is free
//   or drains. Throughput: one request word per cycle while the receiver does not
//   stall, set by the single decode stage between the two registers.
//   Reset (i_rst_n low at a clock edge) empties both registers, clears the
//   entry state and loads the default widths 1, 4 and 2.
//   When the receiver stalls, the result register holds its word and one more
//   request word waits in the input register; i_req.ready then falls.
module xref_stream_entry_decoder #(
    parameter int unsigned MAX_FIELD_BYTES = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    xsed_req_if.sink                    i_req,
    xsed_rsp_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [xsed_pkg::ADDR_W-1:0] paddr,
    input  logic [xsed_pkg::DATA_W-1:0] pwdata,
    output logic [xsed_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import xsed_pkg::*;

    t_cfg w_cfg;
    logic r_in_valid;
    t_req r_in;
    logic w_take;

    xsed_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input register: accepts a new word whenever it is empty or its word moves on.
    assign i_req.ready = !r_in_valid || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.req_type     <= i_req.req_type;
            r_in.data_byte    <= i_req.data_byte;
            r_in.first_object <= i_req.first_object;
            r_in.entry_count  <= i_req.entry_count;
        end
    end

    xsed_decode #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (r_in_valid),
        .i_req   (r_in),
        .o_take  (w_take),
        .o_rsp   (o_rsp)
    );

endmodule
